>>> hdl/vmlsu_pkg.sv
// ----------------------------------------------------------------------------
// vmlsu_pkg: shared types and constants of the load/store unit
// Operation codes, the queue entry type and the default memory size.
// ----------------------------------------------------------------------------
package vmlsu_pkg;

	localparam int MEM_BYTES_DEF = 65536;

	localparam logic [3:0] K_ST8     = 4'd0;
	localparam logic [3:0] K_ST16    = 4'd1;
	localparam logic [3:0] K_ST32    = 4'd2;
	localparam logic [3:0] K_ST64    = 4'd3;
	localparam logic [3:0] K_LD8U    = 4'd4;
	localparam logic [3:0] K_LD8S32  = 4'd5;
	localparam logic [3:0] K_LD8S64  = 4'd6;
	localparam logic [3:0] K_LD16U   = 4'd7;
	localparam logic [3:0] K_LD16S32 = 4'd8;
	localparam logic [3:0] K_LD16S64 = 4'd9;
	localparam logic [3:0] K_LD32U   = 4'd10;
	localparam logic [3:0] K_LD32S64 = 4'd11;
	localparam logic [3:0] K_LD64    = 4'd12;
	localparam logic [3:0] K_FILL    = 4'd13;
	localparam logic [3:0] K_MOVE    = 4'd14;

	// Classified operation handed from front to back.
	typedef struct packed {
		logic [3:0]  kind;
		logic        fault;
		logic        is_st;
		logic        is_ld;
		logic        is_span;   // fill or move with a non-empty span
		logic [3:0]  nbytes;    // 1..8 for single accesses
		logic [31:0] src;
		logic [31:0] dst;
		logic [63:0] data;
		logic [31:0] len;
	} op_t;

endpackage

>>> hdl/vmlsu_if.sv
// ----------------------------------------------------------------------------
// vmlsu_if: valid/ready channel
// Generic handshake channel carrying a payload of parameterised type.
// ----------------------------------------------------------------------------
interface vmlsu_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/vmlsu_ram.sv
// ----------------------------------------------------------------------------
// vmlsu_ram: generic single-port RAM
// One write or read per cycle; read data registered.
// ----------------------------------------------------------------------------
module vmlsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

>>> hdl/vmlsu_front.sv
// ----------------------------------------------------------------------------
// vmlsu_front: decode and bounds check
// Registers each request, classifies it and checks it against memory size.
// ----------------------------------------------------------------------------
module vmlsu_front
	import vmlsu_pkg::*;
#(
	parameter int MEM_BYTES = MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  kind,
	input  logic [31:0] address,
	input  logic [31:0] dest_address,
	input  logic [63:0] store_data,
	input  logic [31:0] span_length,
	output logic        op_valid,
	input  logic        op_ready,
	output op_t         op
);
	localparam logic [32:0] LIMIT = 33'(MEM_BYTES);

	logic [3:0] n;
	logic       st, ld, fl, mv, f;
	logic       src_ok, dst_ok;
	op_t        op_q;
	logic       valid_q;

	always_comb begin
		st = kind <= K_ST64;
		ld = kind >= K_LD8U && kind <= K_LD64;
		fl = kind == K_FILL;
		mv = kind == K_MOVE;
		if (st) begin
			n = 4'd1 << kind[1:0];
		end else if (kind <= K_LD8S64) begin
			n = 4'd1;
		end else if (kind <= K_LD16S64) begin
			n = 4'd2;
		end else if (kind <= K_LD32S64) begin
			n = 4'd4;
		end else begin
			n = 4'd8;
		end
		if (st || ld) begin
			src_ok = ({1'b0, address} + 33'(n)) <= LIMIT;
		end else begin
			src_ok = ({1'b0, address} + {1'b0, span_length}) <= LIMIT;
		end
		dst_ok = ({1'b0, dest_address} + {1'b0, span_length}) <= LIMIT;
		f = ((st || ld || fl) && !src_ok) || (mv && !(src_ok && dst_ok));
	end

	assign in_ready = !valid_q || op_ready;
	assign op_valid = valid_q;
	assign op       = op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_q.kind    <= kind;
			op_q.fault   <= f;
			op_q.is_st   <= st && !f;
			op_q.is_ld   <= ld && !f;
			op_q.is_span <= (fl || mv) && !f && span_length != 32'd0;
			op_q.nbytes  <= n;
			op_q.src     <= address;
			op_q.dst     <= dest_address;
			op_q.data    <= store_data;
			op_q.len     <= span_length;
		end
	end
endmodule

>>> hdl/vmlsu_queue.sv
// ----------------------------------------------------------------------------
// vmlsu_queue: two-entry queue
// Decouples the decode front from the memory back end.
// ----------------------------------------------------------------------------
module vmlsu_queue
	import vmlsu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic w_valid,
	output logic w_ready,
	input  op_t  w_op,
	output logic r_valid,
	input  logic r_ready,
	output op_t  r_op
);
	op_t  ent_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign w_ready = cnt_q != 2'd2;
	assign r_valid = cnt_q != 2'd0;
	assign r_op    = ent_q[rp_q];
	assign push    = w_valid && w_ready;
	assign pop     = r_valid && r_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= w_op;
		end
	end
endmodule

>>> hdl/vmlsu_back.sv
// ----------------------------------------------------------------------------
// vmlsu_back: memory sequencer
// Clears memory after reset, then carries out accesses byte by byte.
// ----------------------------------------------------------------------------
module vmlsu_back
	import vmlsu_pkg::*;
#(
	parameter int MEM_BYTES = MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	output logic        op_ready,
	input  op_t         op,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [63:0] load_data,
	output logic        fault
);
	localparam int AW = $clog2(MEM_BYTES);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;   // read address issued
	localparam logic [2:0] S_RDW  = 3'd3;   // read data arrives
	localparam logic [2:0] S_WR   = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]    state_q;
	logic [AW-1:0] clr_q;
	op_t           cur_q;
	logic [31:0]   i_q;        // byte index within the access
	logic [63:0]   acc_q;
	logic [7:0]    byte_q;
	logic          bwd_q;      // move runs from the top down
	logic          rvalid_q;
	logic [63:0]   rdata_q;
	logic          rfault_q;

	logic          we;
	logic [AW-1:0] addr;
	logic [7:0]    wdata, rdata;
	logic [31:0]   cnt, off;
	logic          last;
	logic [63:0]   ext;

	vmlsu_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	assign cnt  = (cur_q.is_span) ? cur_q.len : 32'(cur_q.nbytes);
	assign off  = bwd_q ? (cnt - 32'd1 - i_q) : i_q;
	assign last = i_q == cnt - 32'd1;

	always_comb begin
		we    = 1'b0;
		wdata = 8'd0;
		addr  = AW'(cur_q.src + off);
		case (state_q)
			S_CLR: begin
				we    = 1'b1;
				addr  = clr_q;
			end
			S_WR: begin
				we = 1'b1;
				if (cur_q.kind == K_MOVE) begin
					addr  = AW'(cur_q.dst + off);
					wdata = byte_q;
				end else if (cur_q.kind == K_FILL) begin
					wdata = cur_q.data[7:0];
				end else begin
					wdata = cur_q.data[8*i_q[2:0] +: 8];
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		case (cur_q.kind)
			K_LD8S32:  ext = {32'd0, {24{acc_q[7]}}, acc_q[7:0]};
			K_LD8S64:  ext = {{56{acc_q[7]}}, acc_q[7:0]};
			K_LD16S32: ext = {32'd0, {16{acc_q[15]}}, acc_q[15:0]};
			K_LD16S64: ext = {{48{acc_q[15]}}, acc_q[15:0]};
			K_LD32S64: ext = {{32{acc_q[31]}}, acc_q[31:0]};
			default:   ext = acc_q;
		endcase
	end

	assign op_ready  = state_q == S_IDLE && !rvalid_q;
	assign res_valid = rvalid_q;
	assign load_data = rdata_q;
	assign fault     = rfault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (rvalid_q && res_ready) rvalid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MEM_BYTES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (op_valid && op_ready) begin
						if (op.is_ld || (op.is_span && op.kind == K_MOVE)) begin
							state_q <= S_RD;
						end else if (op.is_st || op.is_span) begin
							state_q <= S_WR;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_RD:  state_q <= S_RDW;
				S_RDW: begin
					if (cur_q.is_ld) begin
						state_q <= last ? S_DONE : S_RD;
					end else begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					if (last) begin
						state_q <= S_DONE;
					end else begin
						state_q <= (cur_q.kind == K_MOVE) ? S_RD : S_WR;
					end
				end
				S_DONE: begin
					rvalid_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cur_q <= op;
				i_q   <= 32'd0;
				acc_q <= 64'd0;
				// Only a move may walk downwards; single accesses always run upwards.
				bwd_q <= (op.kind == K_MOVE) && (op.dst > op.src);
			end
			S_RDW: begin
				if (cur_q.is_ld) begin
					acc_q[8*i_q[2:0] +: 8] <= rdata;
					i_q <= i_q + 32'd1;
				end else begin
					byte_q <= rdata;
				end
			end
			S_WR: i_q <= i_q + 32'd1;
			S_DONE: begin
				rdata_q  <= cur_q.is_ld ? ext : 64'd0;
				rfault_q <= cur_q.fault;
			end
			default: ;
		endcase
	end
endmodule

>>> hdl/vm_load_store_unit.sv
// ----------------------------------------------------------------------------
// vm_load_store_unit: little-endian memory unit of a virtual machine
// Loads, stores, fill and overlap-safe move over a byte memory.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload
//  req     | in  | kind, address, dest_address, store_data, span_length
//  rsp     | out | load_data, fault
//
// A request is decoded, bounds-checked and registered, then queued. The back
// end uses a single-port byte RAM: stores and fills write byte by byte, a load
// reads each byte, a move reads then writes each; faulting and empty ops
// write nothing. After reset the RAM is cleared one byte a cycle, while no
// op runs. A held response stalls the back end, then via the queue the front.
module vm_load_store_unit
	import vmlsu_pkg::*;
#(
	parameter int MEM_BYTES = MEM_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	vmlsu_if.sink   req,
	vmlsu_if.source rsp
);
	logic op_valid, op_ready, q_valid, q_ready;
	op_t  op, q_op;

	// Front: decode and bounds check.
	vmlsu_front #(.MEM_BYTES(MEM_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.kind(req.payload.kind), .address(req.payload.address),
		.dest_address(req.payload.dest_address),
		.store_data(req.payload.store_data),
		.span_length(req.payload.span_length),
		.op_valid(op_valid), .op_ready(op_ready), .op(op)
	);

	// Queue between the two halves.
	vmlsu_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.w_valid(op_valid), .w_ready(op_ready), .w_op(op),
		.r_valid(q_valid), .r_ready(q_ready), .r_op(q_op)
	);

	// Back: memory sequencer and response register.
	vmlsu_back #(.MEM_BYTES(MEM_BYTES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.op_valid(q_valid), .op_ready(q_ready), .op(q_op),
		.res_valid(rsp.valid), .res_ready(rsp.ready),
		.load_data(rsp.payload.load_data), .fault(rsp.payload.fault)
	);
endmodule

>>> tb/vmlsu_tb_types.sv
// ----------------------------------------------------------------------------
// vmlsu_tb_types: request and response beats of the load/store unit
// Payload structures carried on the request and response channels.
// ----------------------------------------------------------------------------
package vmlsu_tb_types;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] address;
		logic [31:0] dest_address;
		logic [63:0] store_data;
		logic [31:0] span_length;
	} lsu_req_t;

	typedef struct packed {
		logic [63:0] load_data;
		logic        fault;
	} lsu_rsp_t;

endpackage

>>> tb/vm_load_store_unit_tb.sv
// ----------------------------------------------------------------------------
// vm_load_store_unit_tb: self-checking bench of the load/store unit
// A directed table of memory operations is followed by about 700 random
// ones, with bursty requests and a stalling response side. Every response
// beat is checked against the table or a byte-level memory image in the bench.
// ----------------------------------------------------------------------------
module vm_load_store_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vmlsu_pkg::*;
	import vmlsu_tb_types::*;

	localparam int MEM = MEM_BYTES_DEF;
	localparam int N_RANDOM = 700;
	localparam logic [3:0] K_UNUSED = 4'd15;

	// One directed row: the operation and, where it can be read off directly,
	// the response it must give.
	typedef struct {
		lsu_req_t    op;
		bit          known;
		logic [63:0] data;
		logic        fault;
	} row_t;

	logic clk;
	logic arst_n;

	vmlsu_if #(.T(lsu_req_t)) req ();
	vmlsu_if #(.T(lsu_rsp_t)) rsp ();

	vm_load_store_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Image of the memory as the block should hold it.
	logic [7:0] mem_image [MEM];
	// Responses owed by the block, oldest first.
	lsu_rsp_t   owed_rsp [$];
	row_t       rows [$];
	int         n_errors;
	int         n_accepted;
	bit         all_sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	// An access of n bytes at a lies inside memory when a + n <= MEM,
	// the sum being formed without wrap.
	function automatic bit span_fits(logic [31:0] a, logic [31:0] n);
		return ({32'd0, a} + {32'd0, n}) <= 64'(MEM);
	endfunction

	function automatic logic [63:0] sign_ext(logic [63:0] v, int bits);
		logic [63:0] mask;
		mask = (64'd1 << bits) - 64'd1;
		v = v & mask;
		if (v[bits-1]) begin
			v = v | ~mask;
		end
		return v;
	endfunction

	// Applies one operation to the memory image and gives back the response.
	function automatic lsu_rsp_t apply_op(lsu_req_t op);
		lsu_rsp_t    r;
		int          n;
		logic [63:0] v;
		r = '0;
		n = 0;
		v = '0;
		case (op.kind)
			K_ST8, K_ST16, K_ST32, K_ST64: begin
				n = 1 << op.kind;
				if (span_fits(op.address, n)) begin
					for (int i = 0; i < n; i++)
						mem_image[op.address + i] = op.store_data[8*i +: 8];
				end else begin
					r.fault = 1'b1;
				end
			end
			K_FILL: begin
				if (span_fits(op.address, op.span_length)) begin
					for (longint i = 0; i < op.span_length; i++)
						mem_image[op.address + i] = op.store_data[7:0];
				end else begin
					r.fault = 1'b1;
				end
			end
			K_MOVE: begin
				if (span_fits(op.address, op.span_length)
						&& span_fits(op.dest_address, op.span_length)) begin
					// Copy in the direction that never reads a byte it has overwritten.
					if (op.dest_address <= op.address) begin
						for (longint i = 0; i < op.span_length; i++)
							mem_image[op.dest_address + i] = mem_image[op.address + i];
					end else begin
						for (longint i = op.span_length - 1; i >= 0; i--)
							mem_image[op.dest_address + i] = mem_image[op.address + i];
					end
				end else begin
					r.fault = 1'b1;
				end
			end
			K_UNUSED: begin
			end
			default: begin
				// Loads.
				if (op.kind <= K_LD8S64) begin
					n = 1;
				end else if (op.kind <= K_LD16S64) begin
					n = 2;
				end else if (op.kind <= K_LD32S64) begin
					n = 4;
				end else begin
					n = 8;
				end
				if (!span_fits(op.address, n)) begin
					r.fault = 1'b1;
				end else begin
					for (int i = 0; i < n; i++)
						v[8*i +: 8] = mem_image[op.address + i];
					case (op.kind)
						K_LD8S32:  r.load_data = sign_ext(v, 8) & 64'hffff_ffff;
						K_LD8S64:  r.load_data = sign_ext(v, 8);
						K_LD16S32: r.load_data = sign_ext(v, 16) & 64'hffff_ffff;
						K_LD16S64: r.load_data = sign_ext(v, 16);
						K_LD32S64: r.load_data = sign_ext(v, 32);
						default:   r.load_data = v;
					endcase
				end
			end
		endcase
		return r;
	endfunction

	function automatic void add_row(logic [3:0] k, logic [31:0] a, logic [31:0] d,
			logic [63:0] sd, logic [31:0] len, bit known = 0,
			logic [63:0] ed = '0, logic ef = 1'b0);
		row_t r;
		r.op = '{kind: k, address: a, dest_address: d, store_data: sd, span_length: len};
		r.known = known;
		r.data = ed;
		r.fault = ef;
		rows.push_back(r);
	endfunction

	function automatic logic [31:0] rand_addr();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			return $urandom_range(0, 255);
		end else if (sel < 70) begin
			return $urandom_range(MEM - 256, MEM + 8);
		end else if (sel < 90) begin
			return $urandom_range(0, MEM - 1);
		end
		return $urandom;
	endfunction

	function automatic lsu_req_t rand_op();
		lsu_req_t op;
		int       sel;
		op.kind = 4'($urandom_range(0, 15));
		op.address = rand_addr();
		op.dest_address = rand_addr();
		op.store_data = {$urandom, $urandom};
		sel = $urandom_range(0, 99);
		// Spans are mostly short so the byte-serial fill and move stay quick.
		if (sel < 85) begin
			op.span_length = $urandom_range(0, 32);
		end else if (sel < 97) begin
			op.span_length = $urandom_range(0, 2048);
		end else begin
			op.span_length = $urandom;
		end
		return op;
	endfunction

	// Request side: bursts of beats with idle gaps between them. A beat
	// counts as accepted when ready is seen high at the falling edge, since
	// valid and ready only change at rising edges.
	task automatic send_op(lsu_req_t op, lsu_rsp_t owed);
		req.valid <= 1'b1;
		req.payload <= op;
		forever begin
			@(negedge clk);
			if (req.ready) begin
				break;
			end
			@(posedge clk);
		end
		owed_rsp.push_back(owed);
		n_accepted++;
		@(posedge clk);
	endtask

	int burst_left;

	task automatic offer(lsu_req_t op, lsu_rsp_t owed);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		send_op(op, owed);
	endtask

	initial begin
		lsu_rsp_t owed;
		lsu_req_t op;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.payload = '0;
		n_errors = 0;
		n_accepted = 0;
		all_sent = 1'b0;
		burst_left = 0;
		foreach (mem_image[i]) mem_image[i] = 8'h00;

		// Directed table. Reads of memory straight after reset give zero.
		add_row(K_LD64, 0, 0, 0, 0, 1, 64'h0, 0);
		add_row(K_ST64, 0, 0, 64'h8081_8283_8485_8687, 0, 1, 64'h0, 0);
		add_row(K_LD8U, 0, 0, 0, 0, 1, 64'h87, 0);
		add_row(K_LD8S32, 0, 0, 0, 0, 1, 64'h0000_0000_ffff_ff87, 0);
		add_row(K_LD8S64, 0, 0, 0, 0, 1, 64'hffff_ffff_ffff_ff87, 0);
		add_row(K_LD16U, 0, 0, 0, 0, 1, 64'h8687, 0);
		add_row(K_LD16S32, 0, 0, 0, 0, 1, 64'h0000_0000_ffff_8687, 0);
		add_row(K_LD16S64, 0, 0, 0, 0, 1, 64'hffff_ffff_ffff_8687, 0);
		add_row(K_LD32U, 0, 0, 0, 0, 1, 64'h8485_8687, 0);
		add_row(K_LD32S64, 0, 0, 0, 0, 1, 64'hffff_ffff_8485_8687, 0);
		add_row(K_LD64, 0, 0, 0, 0, 1, 64'h8081_8283_8485_8687, 0);
		// Accesses at the top of memory, the last byte in bounds and just past it.
		add_row(K_ST8, MEM - 1, 0, 64'hffff_ffff_ffff_ff5a, 0, 1, 64'h0, 0);
		add_row(K_ST16, MEM - 1, 0, 64'h1234, 0, 1, 64'h0, 1);
		add_row(K_ST32, 32'hffff_ffff, 0, 64'h1234, 0, 1, 64'h0, 1);
		add_row(K_ST64, MEM - 8, 0, 64'h7f6e_5d4c_3b2a_1908, 0, 1, 64'h0, 0);
		add_row(K_LD64, MEM - 7, 0, 0, 0, 1, 64'h0, 1);
		add_row(K_LD8U, MEM - 1, 0, 0, 0);
		// Empty spans fault only when the start lies beyond the end of memory.
		add_row(K_FILL, MEM, 0, 64'hab, 0, 1, 64'h0, 0);
		add_row(K_FILL, MEM + 1, 0, 64'hab, 0, 1, 64'h0, 1);
		add_row(K_FILL, 32'hffff_ffff, 0, 64'hab, 32'hffff_ffff, 1, 64'h0, 1);
		add_row(K_MOVE, MEM, 0, 0, 0, 1, 64'h0, 0);
		add_row(K_MOVE, 0, MEM - 1, 0, 2, 1, 64'h0, 1);
		// Overlapping moves in both directions.
		add_row(K_MOVE, 0, 3, 0, 8);
		add_row(K_LD64, 0, 0, 0, 0);
		add_row(K_MOVE, 4, 0, 0, 8);
		add_row(K_UNUSED, 32'hffff_ffff, 32'hffff_ffff, '1, '1, 1, 64'h0, 0);
		add_row(K_FILL, 0, 0, 64'ha5, MEM, 1, 64'h0, 0);
		add_row(K_LD64, 12345, 0, 0, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			owed = apply_op(rows[i].op);
			if (rows[i].known) begin
				owed.load_data = rows[i].data;
				owed.fault = rows[i].fault;
			end
			offer(rows[i].op, owed);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			op = rand_op();
			owed = apply_op(op);
			offer(op, owed);
		end
		req.valid <= 1'b0;
		all_sent = 1'b1;
	end

	// Response side: ready follows one of four stall patterns, each picked at
	// random, with one long hold-off once the traffic is under way.
	initial begin
		int  mode;
		bit  held;
		rsp.ready = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(10, 60)) begin
				@(posedge clk);
				case (mode)
					0: rsp.ready <= 1'b1;
					1: rsp.ready <= ($urandom_range(0, 3) != 0);
					2: rsp.ready <= ($urandom_range(0, 3) == 0);
					default: rsp.ready <= ~rsp.ready;
				endcase
			end
			if (!held && n_accepted >= 60) begin
				held = 1'b1;
				@(posedge clk);
				rsp.ready <= 1'b0;
				repeat (500) @(posedge clk);
			end
		end
	end

	// Response checker.
	initial begin
		lsu_rsp_t want;
		forever begin
			@(negedge clk);
			if (arst_n && rsp.valid && rsp.ready) begin
				if (owed_rsp.size() == 0) begin
					$display("%t: response with none owed: load_data %h fault %b",
						$realtime, rsp.payload.load_data, rsp.payload.fault);
					n_errors++;
				end else begin
					want = owed_rsp.pop_front();
					if (rsp.payload.load_data !== want.load_data) begin
						$display("%t: load_data expected %h actual %h",
							$realtime, want.load_data, rsp.payload.load_data);
						n_errors++;
					end
					if (rsp.payload.fault !== want.fault) begin
						$display("%t: fault expected %b actual %b",
							$realtime, want.fault, rsp.payload.fault);
						n_errors++;
					end
				end
			end
		end
	end

	// End of run.
	initial begin
		wait (all_sent);
		wait (owed_rsp.size() == 0);
		repeat (50) @(posedge clk);
		if (n_errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
